/* design/svfd_pkg.sv */
`timescale 1ns / 1ps

package svfd_pkg;

    // Field widths of one transaction
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned CHAN_W   = 5;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned CNT_W    = 8;

    // Channel decode
    localparam logic [3:0]        EXT_FIELD     = 4'd12;
    localparam logic [CHAN_W-1:0] EXT_BASE      = 5'd12;
    localparam logic [CHAN_W-1:0] PHASE_OFFSET  = 5'd4;

    // Reset values
    localparam logic [CNT_W-1:0] CENTER_PKTS_RST = 8'd9;
    localparam logic [POS_W-1:0] POS_NO_DATA     = 16'hffff;

    // Item kinds
    typedef enum logic {
        KIND_SERVO = 1'b0,
        KIND_READ  = 1'b1
    } t_kind;

    // One result transaction
    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  center;
        logic              written;
        logic              centers_captured;
    } t_result;

endpackage

/* design/svfd_in_if.sv */
`timescale 1ns / 1ps

interface svfd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [svfd_pkg::WORD_W-1:0]   word;
    logic                          first_in_packet;
    logic                          last_in_packet;
    logic [svfd_pkg::CHAN_W-1:0]   read_index;

    modport source (
        output valid, kind, word, first_in_packet, last_in_packet, read_index,
        input  ready
    );
    modport sink (
        input  valid, kind, word, first_in_packet, last_in_packet, read_index,
        output ready
    );
endinterface

/* design/svfd_out_if.sv */
`timescale 1ns / 1ps

interface svfd_out_if;
    logic                          valid;
    logic                          ready;
    logic [svfd_pkg::CHAN_W-1:0]   channel;
    logic [svfd_pkg::POS_W-1:0]    position;
    logic [svfd_pkg::POS_W-1:0]    center;
    logic                          written;
    logic                          centers_captured;

    modport source (
        output valid, channel, position, center, written, centers_captured,
        input  ready
    );
    modport sink (
        input  valid, channel, position, center, written, centers_captured,
        output ready
    );
endinterface

/* design/servo_frame_channel_decoder.sv */
`timescale 1ns / 1ps

// Servo frame channel decoder. Takes one transaction per clock while the skid
// stage is empty: either a raw servo word of a radio packet (byte-swapped,
// decoded to a channel and stored) or a read query for one channel. Every
// transaction gives exactly one registered result, through an output register
// backed by a one-entry skid stage, so input and output stall independently.
// The rate is set by the single decode-and-write pass; the centre capture copies
// all stored positions into the centre store within the same cycle. Writing the
// centring register reloads the packet countdown; it must be written while idle.
module servo_frame_channel_decoder #(
    parameter int unsigned CHANNELS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [svfd_pkg::CNT_W-1:0]    i_cfg_wdata,
    svfd_in_if.sink                       i_in,
    svfd_out_if.source                    o_out
);

    localparam int unsigned IDX_W = $clog2(CHANNELS);
    localparam logic [svfd_pkg::CHAN_W:0] CHAN_LIMIT = (svfd_pkg::CHAN_W+1)'(CHANNELS);

    // State
    logic                          r_phase;
    logic [svfd_pkg::POS_W-1:0]    r_pos    [CHANNELS];
    logic [svfd_pkg::POS_W-1:0]    r_center [CHANNELS];
    logic [svfd_pkg::CNT_W-1:0]    r_countdown;

    // Output register and skid stage
    logic                          r_out_valid;
    svfd_pkg::t_result             r_out;
    logic                          r_skid_valid;
    svfd_pkg::t_result             r_skid;

    logic                          accept;
    logic                          drain;

    // Decode signals
    logic [svfd_pkg::WORD_W-1:0]   data;
    logic [3:0]                    field;
    logic                          eff_phase;
    logic [svfd_pkg::CHAN_W-1:0]   dec_chan;
    logic [svfd_pkg::POS_W-1:0]    dec_val;
    logic                          dec_hit;
    logic                          wr;
    logic                          step;
    logic                          cap;
    logic                          read_in_range;
    logic [IDX_W-1:0]              wr_idx;
    logic [IDX_W-1:0]              rd_idx;
    svfd_pkg::t_result             res;

    assign i_in.ready = !r_skid_valid;
    assign accept     = i_in.valid && i_in.ready;
    assign drain      = r_out_valid && o_out.ready;

    // Byte swap and channel field decode
    always_comb begin
        data      = {i_in.word[7:0], i_in.word[15:8]};
        field     = data[14:11];
        eff_phase = i_in.first_in_packet ? data[15] : r_phase;
        dec_chan  = '0;
        dec_val   = '0;
        dec_hit   = 1'b0;
        if (field < svfd_pkg::EXT_FIELD) begin
            dec_chan = {1'b0, field};
            dec_val  = {5'b0, data[10:0]};
            dec_hit  = 1'b1;
        end else if (field == svfd_pkg::EXT_FIELD) begin
            dec_chan = svfd_pkg::EXT_BASE + {3'b0, data[10:9]}
                       + (eff_phase ? svfd_pkg::PHASE_OFFSET : '0);
            dec_val  = {5'b0, data[8:0], 2'b0};
            dec_hit  = 1'b1;
        end
    end

    assign wr     = (i_in.kind == svfd_pkg::KIND_SERVO) && dec_hit
                    && ({1'b0, dec_chan} < CHAN_LIMIT);
    assign step   = (i_in.kind == svfd_pkg::KIND_SERVO) && i_in.last_in_packet
                    && (r_countdown != '0);
    assign cap    = step && (r_countdown == svfd_pkg::CNT_W'(1));
    assign wr_idx = dec_chan[IDX_W-1:0];
    assign rd_idx = i_in.read_index[IDX_W-1:0];
    assign read_in_range = {1'b0, i_in.read_index} < CHAN_LIMIT;

    // Result of the current transaction
    always_comb begin
        res = '0;
        if (i_in.kind == svfd_pkg::KIND_READ) begin
            res.channel  = i_in.read_index;
            res.position = read_in_range ? r_pos[rd_idx] : svfd_pkg::POS_NO_DATA;
            res.center   = read_in_range ? r_center[rd_idx] : '0;
        end else begin
            res.centers_captured = cap;
            if (wr) begin
                res.channel  = dec_chan;
                res.position = dec_val;
                res.center   = cap ? dec_val : r_center[wr_idx];
                res.written  = 1'b1;
            end
        end
    end

    // Phase and packet countdown; a register write reloads the countdown
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_countdown <= svfd_pkg::CENTER_PKTS_RST;
        end else begin
            if (i_cfg_we) begin
                r_countdown <= i_cfg_wdata;
            end else if (accept && step) begin
                r_countdown <= r_countdown - svfd_pkg::CNT_W'(1);
            end
            if (accept && i_in.kind == svfd_pkg::KIND_SERVO && i_in.first_in_packet) begin
                r_phase <= data[15];
            end
        end
    end

    // Position and centre stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_pos[i]    <= svfd_pkg::POS_NO_DATA;
                r_center[i] <= '0;
            end
        end else if (accept) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (wr && wr_idx == IDX_W'(i)) begin
                    r_pos[i] <= dec_val;
                end
                if (cap) begin
                    r_center[i] <= (wr && wr_idx == IDX_W'(i)) ? dec_val : r_pos[i];
                end
            end
        end
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || drain) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= accept;
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || drain) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= res;
            end
        end
        if (accept && !(!r_out_valid || drain)) begin
            r_skid <= res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.channel          = r_out.channel;
    assign o_out.position         = r_out.position;
    assign o_out.center           = r_out.center;
    assign o_out.written          = r_out.written;
    assign o_out.centers_captured = r_out.centers_captured;

endmodule

/* tb/servo_frame_channel_decoder_tb.sv */
`timescale 1ns / 1ps

module servo_frame_channel_decoder_tb;

    localparam int unsigned CHANNELS    = 20;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned DIR_ROWS    = 21;
    localparam int unsigned NUM_PHASES  = 8;
    localparam int unsigned PHASE_ITEMS = 110;

    localparam svfd_pkg::t_kind K_READ  = svfd_pkg::KIND_READ;
    localparam svfd_pkg::t_kind K_SERVO = svfd_pkg::KIND_SERVO;

    // One directed row: the item and, where obvious, its result typed in
    typedef struct packed {
        logic                        kind;
        logic [svfd_pkg::WORD_W-1:0] word;
        logic                        first;
        logic                        last;
        logic [svfd_pkg::CHAN_W-1:0] ridx;
        logic                        has_lit;
        svfd_pkg::t_result           lit;
    } t_dir_row;

    // Typed-in result attached to an item on offer
    typedef struct packed {
        logic              has;
        svfd_pkg::t_result r;
    } t_lit;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [svfd_pkg::CNT_W-1:0] i_cfg_wdata;

    svfd_in_if  in_ch ();
    svfd_out_if out_ch ();

    servo_frame_channel_decoder #(
        .CHANNELS (CHANNELS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Predicted decoder state
    logic                       phase_q;
    logic [svfd_pkg::POS_W-1:0] pos_store [CHANNELS];
    logic [svfd_pkg::POS_W-1:0] ctr_store [CHANNELS];
    logic [svfd_pkg::CNT_W-1:0] pkts_left;

    svfd_pkg::t_result pending_results [$];
    t_lit              typed_results [$];
    t_dir_row          dir_tab [DIR_ROWS];

    int  err_cnt   = 0;
    int  items_sent = 0;
    int  calm_left = 0;
    bit  quiet     = 1'b0;
    bit  hold_req  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Decode one transaction and advance the predicted state
    function automatic svfd_pkg::t_result decode_item(logic kind,
                                                      logic [svfd_pkg::WORD_W-1:0] raw,
                                                      logic first, logic last,
                                                      logic [svfd_pkg::CHAN_W-1:0] ridx);
        svfd_pkg::t_result           r;
        logic [15:0]                 data;
        logic [3:0]                  fld;
        logic [svfd_pkg::CHAN_W-1:0] ch;
        logic [svfd_pkg::POS_W-1:0]  val;
        logic                        hit;
        r = '0;
        if (svfd_pkg::t_kind'(kind) == svfd_pkg::KIND_READ) begin
            r.channel = ridx;
            if (ridx < CHANNELS) begin
                r.position = pos_store[ridx];
                r.center   = ctr_store[ridx];
            end else begin
                r.position = svfd_pkg::POS_NO_DATA;
            end
        end else begin
            data = {raw[7:0], raw[15:8]};
            fld  = data[14:11];
            ch   = {1'b0, fld};
            val  = '0;
            hit  = 1'b0;
            if (first)
                phase_q = data[15];
            if (fld < svfd_pkg::EXT_FIELD) begin
                val = {5'd0, data[10:0]};
                hit = 1'b1;
            end else if (fld == svfd_pkg::EXT_FIELD) begin
                ch  = svfd_pkg::EXT_BASE + {3'd0, data[10:9]}
                      + (phase_q ? svfd_pkg::PHASE_OFFSET : 5'd0);
                val = {5'd0, data[8:0], 2'b00};
                hit = 1'b1;
            end
            if (hit && ch < CHANNELS) begin
                pos_store[ch] = val;
                r.channel  = ch;
                r.position = val;
                r.written  = 1'b1;
            end
            // countdown steps after the write, so a capture includes it
            if (last && pkts_left != 0) begin
                pkts_left = pkts_left - 1'b1;
                if (pkts_left == 0) begin
                    ctr_store = pos_store;
                    r.centers_captured = 1'b1;
                end
            end
            if (r.written)
                r.center = ctr_store[ch];
        end
        return r;
    endfunction

    // Scoreboard: check results, then track config writes and accepted items
    always @(posedge i_clk) begin
        svfd_pkg::t_result want;
        t_lit              typed;
        if (!i_rst_n) begin
            phase_q   = 1'b0;
            pkts_left = svfd_pkg::CENTER_PKTS_RST;
            for (int i = 0; i < CHANNELS; i++) begin
                pos_store[i] = svfd_pkg::POS_NO_DATA;
                ctr_store[i] = '0;
            end
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with none pending: channel %0d", out_ch.channel);
                    err_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.channel !== want.channel) begin
                        $error("channel: expected %0d, actual %0d",
                               want.channel, out_ch.channel);
                        err_cnt++;
                    end
                    if (out_ch.position !== want.position) begin
                        $error("position: expected %h, actual %h",
                               want.position, out_ch.position);
                        err_cnt++;
                    end
                    if (out_ch.center !== want.center) begin
                        $error("center: expected %h, actual %h",
                               want.center, out_ch.center);
                        err_cnt++;
                    end
                    if (out_ch.written !== want.written) begin
                        $error("written: expected %b, actual %b",
                               want.written, out_ch.written);
                        err_cnt++;
                    end
                    if (out_ch.centers_captured !== want.centers_captured) begin
                        $error("centers_captured: expected %b, actual %b",
                               want.centers_captured, out_ch.centers_captured);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_we)
                pkts_left = i_cfg_wdata;
            if (in_ch.valid && in_ch.ready) begin
                want  = decode_item(in_ch.kind, in_ch.word, in_ch.first_in_packet,
                                    in_ch.last_in_packet, in_ch.read_index);
                typed = typed_results.pop_front();
                if (typed.has)
                    want = typed.r;
                pending_results.push_back(want);
            end
        end
    end

    // Result side back-pressure: short bursts, calm stretches, one long hold
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 19) == 0) begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one transaction and return at the edge where it is taken
    task automatic send_item(logic kind, logic [svfd_pkg::WORD_W-1:0] word, logic first,
                             logic last, logic [svfd_pkg::CHAN_W-1:0] ridx,
                             logic has_lit, svfd_pkg::t_result lit);
        t_lit typed;
        if (calm_left > 0) begin
            calm_left--;
        end else if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(20, 60);
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        typed.has = has_lit;
        typed.r   = lit;
        typed_results.push_back(typed);
        in_ch.valid           <= 1'b1;
        in_ch.kind            <= kind;
        in_ch.word            <= word;
        in_ch.first_in_packet <= first;
        in_ch.last_in_packet  <= last;
        in_ch.read_index      <= ridx;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Stop offering and wait until every pending result is out
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_centering(logic [svfd_pkg::CNT_W-1:0] value);
        drain_results();
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_read(logic [svfd_pkg::CHAN_W-1:0] ridx);
        send_item(svfd_pkg::KIND_READ, svfd_pkg::WORD_W'($urandom), 1'($urandom),
                  1'($urandom), ridx, 1'b0, '0);
    endtask

    task automatic send_servo(logic [15:0] data, logic first, logic last);
        send_item(svfd_pkg::KIND_SERVO, {data[7:0], data[15:8]}, first, last,
                  svfd_pkg::CHAN_W'($urandom), 1'b0, '0);
    endtask

    // Little-endian servo word: mostly plain channels, some extended, a few unused
    function automatic logic [15:0] rand_servo_data();
        int unsigned pick;
        logic [3:0]  fld;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            fld = 4'($urandom_range(0, 11));
        else if (pick < 90)
            fld = svfd_pkg::EXT_FIELD;
        else
            fld = 4'($urandom_range(13, 15));
        return {1'($urandom), fld, 11'($urandom)};
    endfunction

    function automatic logic [svfd_pkg::CHAN_W-1:0] rand_read_index();
        if ($urandom_range(0, 4) == 0)
            return svfd_pkg::CHAN_W'($urandom_range(CHANNELS, 31));
        return svfd_pkg::CHAN_W'($urandom_range(0, CHANNELS - 1));
    endfunction

    // Packet of servo words, with queries mixed in; a broken one has no last mark
    task automatic send_packet(int unsigned n_words, logic with_last);
        for (int unsigned i = 0; i < n_words; i++) begin
            if ($urandom_range(0, 7) == 0)
                send_read(rand_read_index());
            send_servo(rand_servo_data(), i == 0, with_last && i == n_words - 1);
        end
    endtask

    initial begin
        // edge cases read straight off the behaviour; blank rows are predicted
        dir_tab = '{
            '{K_READ,  16'h0000, 1'b0, 1'b0, 5'd0,  1'b1, '{5'd0,  16'hffff, 16'h0, 1'b0, 1'b0}},
            '{K_READ,  16'h0000, 1'b0, 1'b0, 5'd19, 1'b1, '{5'd19, 16'hffff, 16'h0, 1'b0, 1'b0}},
            '{K_READ,  16'h0000, 1'b0, 1'b0, 5'd20, 1'b1, '{5'd20, 16'hffff, 16'h0, 1'b0, 1'b0}},
            '{K_READ,  16'hffff, 1'b1, 1'b1, 5'd31, 1'b1, '{5'd31, 16'hffff, 16'h0, 1'b0, 1'b0}},
            '{K_SERVO, 16'hff07, 1'b1, 1'b0, 5'd0,  1'b1, '{5'd0,  16'h07ff, 16'h0, 1'b1, 1'b0}},
            '{K_SERVO, 16'h0058, 1'b0, 1'b0, 5'd31, 1'b1, '{5'd11, 16'h0000, 16'h0, 1'b1, 1'b0}},
            '{K_SERVO, 16'hff6f, 1'b0, 1'b1, 5'd0,  1'b1, '{5'd0,  16'h0000, 16'h0, 1'b0, 1'b0}},
            '{K_SERVO, 16'hffff, 1'b1, 1'b1, 5'd0,  1'b1, '{5'd0,  16'h0000, 16'h0, 1'b0, 1'b0}},
            '{K_SERVO, 16'hff67, 1'b0, 1'b1, 5'd0,  1'b1, '{5'd19, 16'h07fc, 16'h0, 1'b1, 1'b0}},
            '{K_SERVO, 16'h0060, 1'b1, 1'b1, 5'd0,  1'b1, '{5'd12, 16'h0000, 16'h0, 1'b1, 1'b0}},
            '{K_SERVO, 16'h01e0, 1'b1, 1'b0, 5'd0,  1'b0, '0},
            '{K_SERVO, 16'haa62, 1'b0, 1'b1, 5'd0,  1'b0, '0},
            '{K_SERVO, 16'h552d, 1'b0, 1'b1, 5'd0,  1'b0, '0},
            '{K_SERVO, 16'h2371, 1'b0, 1'b1, 5'd0,  1'b1, '{5'd0,  16'h0000, 16'h0, 1'b0, 1'b0}},
            '{K_SERVO, 16'haa1a, 1'b0, 1'b1, 5'd0,  1'b0, '0},
            '{K_SERVO, 16'h003c, 1'b0, 1'b1, 5'd0,  1'b0, '0},
            '{K_SERVO, 16'h0138, 1'b0, 1'b1, 5'd0,  1'b0, '0},
            '{K_READ,  16'h0000, 1'b0, 1'b0, 5'd7,  1'b0, '0},
            '{K_READ,  16'h0000, 1'b0, 1'b0, 5'd19, 1'b0, '0},
            '{K_READ,  16'h0000, 1'b0, 1'b0, 5'd16, 1'b0, '0},
            '{K_READ,  16'h0000, 1'b0, 1'b0, 5'd12, 1'b0, '0}
        };

        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_wdata           <= '0;
        in_ch.valid           <= 1'b0;
        in_ch.kind            <= svfd_pkg::KIND_SERVO;
        in_ch.word            <= '0;
        in_ch.first_in_packet <= 1'b0;
        in_ch.last_in_packet  <= 1'b0;
        in_ch.read_index      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset countdown of nine packets
        foreach (dir_tab[i])
            send_item(dir_tab[i].kind, dir_tab[i].word, dir_tab[i].first,
                      dir_tab[i].last, dir_tab[i].ridx, dir_tab[i].has_lit,
                      dir_tab[i].lit);

        // random phases over several countdown settings, extremes included
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            int unsigned                target;
            logic [svfd_pkg::CNT_W-1:0] pkts;
            bit                         mid_done;
            case (ph)
                0: pkts = 8'd0;
                1: pkts = 8'd1;
                2: pkts = 8'd255;
                3: pkts = 8'd2;
                4: pkts = 8'd5;
                5: pkts = 8'd3;
                6: pkts = svfd_pkg::CNT_W'($urandom_range(1, 20));
                default: pkts = 8'd1;
            endcase
            if (ph == NUM_PHASES - 1)
                quiet = 1'b1;
            write_centering(pkts);
            target   = items_sent + PHASE_ITEMS;
            mid_done = 1'b0;
            while (items_sent < target) begin
                int unsigned pick;
                // halfway through: a long receiver hold, or a full drain
                if (!mid_done && items_sent + PHASE_ITEMS / 2 >= target) begin
                    mid_done = 1'b1;
                    if (ph == 2)
                        hold_req = 1'b1;
                    if (ph == 3)
                        drain_results();
                end
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    send_packet(7, 1'b1);
                else if (pick == 7)
                    send_read(rand_read_index());
                else if (pick == 8)
                    send_item(svfd_pkg::KIND_SERVO, svfd_pkg::WORD_W'($urandom),
                              1'($urandom), 1'($urandom), svfd_pkg::CHAN_W'($urandom),
                              1'b0, '0);
                else
                    send_packet($urandom_range(1, 6), 1'($urandom));
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
